@@ hw/rtl/arsc_pkg.sv @@
// Package: types and constants shared by the ratiometric ADC scaler.
`default_nettype none

package arsc_pkg;

    localparam int ADC_W      = 12;
    localparam int VOLT_W     = 16;
    localparam int TEMP_W     = 9;
    localparam int REF_W      = 12;
    localparam int SLOPE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // quotient widths of the four dividers (bat and led share VOLT_Q_W; all saturating)
    localparam int VOLT_Q_W  = VOLT_W + 1;
    localparam int SENSE_Q_W = 13;
    localparam int TEMP_Q_W  = 9;

    localparam int BAT_NUM_W = 8;
    localparam int LED_NUM_W = 7;
    localparam int DEN_W     = 5;

    localparam logic [BAT_NUM_W-1:0] BAT_NUM = 8'd247;
    localparam logic [LED_NUM_W-1:0] LED_NUM = 7'd74;
    localparam logic [DEN_W-1:0]     DIV_DEN = 5'd27;

    localparam logic [VOLT_W-1:0] VOLT_MAX = 16'hFFFF;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -9'sd65;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 9'sd150;
    localparam logic [TEMP_Q_W-1:0]      TEMP_OFS = 9'd25;
    localparam logic [TEMP_Q_W-1:0]      TEMP_NEG_LIM = 9'd90;
    localparam logic [TEMP_Q_W-1:0]      TEMP_POS_LIM = 9'd125;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_25   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE      = 2'd2;

    localparam logic [REF_W-1:0]   REF_MV_RST   = 12'd1200;
    localparam logic [REF_W-1:0]   SENSE_25_RST = 12'd1430;
    localparam logic [SLOPE_W-1:0] SLOPE_RST    = 8'd43;

    typedef struct packed {
        logic [ADC_W-1:0] bat_raw;
        logic [ADC_W-1:0] led_raw;
        logic [ADC_W-1:0] temp_raw;
        logic [ADC_W-1:0] vref_raw;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]               pad;
        logic                     ref_zero;
        logic                     volt_saturated;
        logic signed [TEMP_W-1:0] temp_c;
        logic [VOLT_W-1:0]        led_mv;
        logic [VOLT_W-1:0]        bat_mv;
    } out_beat_t;

    typedef struct packed {
        logic [VOLT_Q_W-1:0] bat_q;
        logic                bat_ovf;
        logic [VOLT_Q_W-1:0] led_q;
        logic                led_ovf;
    } volt_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/arsc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, quotient overflow flagged.
`default_nettype none

module arsc_div #(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int QW = 17
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo,
    output logic               ovf
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] quo_reg [1:QW];
    logic          ovf_reg [0:QW];

    // stage 0: quotient does not fit in QW bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            ovf_reg[0] <= CW'(num) >= (CW'(den) << QW);
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int B = QW - k;
        logic [CW-1:0] dsh;
        logic [CW-1:0] diff;
        logic          take;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] quo_next;

        if (k == 1)
        begin : g_first
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            dsh         = CW'(den_reg[k-1]) << B;
            take        = CW'(rem_reg[k-1]) >= dsh;
            diff        = CW'(rem_reg[k-1]) - dsh;
            quo_next    = quo_in;
            quo_next[B] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_next;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? diff[NW-1:0] : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

@@ hw/rtl/arsc_delay.sv @@
// Enabled shift-register delay line for payload alignment.
`default_nettype none

module arsc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);

    logic [W-1:0] data_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign dout = data_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ hw/rtl/adc_ratiometric_scaler_top.sv @@
// Top level: ratiometric ADC scaler, supply-independent mV and die temperature.
// Usage:
//   Slave stream s_*: one beat per ADC sample set (reference, temperature,
//   LED and battery readings). Master stream m_*: one result beat per set,
//   in order (battery mV, LED mV, temperature in C, saturation and
//   zero-reference flags).
//   Config port cfg_*: cfg_we with cfg_index/cfg_wdata writes ref_mv (0),
//   sense_at_25_mv (1) or slope_tenth_mv (2); other indexes are ignored.
//   Write only while no beat is in flight.
// Timing:
//   Accepts one beat per cycle while the output is not stalled. A result
//   appears on m_* after 2 product stages, the 14-stage sense divider,
//   1 scaling stage, the 10-stage temperature divider and the output
//   register, the first loaded by the edge that took its input beat (voltage
//   path delayed to match). The whole pipeline advances on one enable; when
//   m_tready is low with a result held, every stage freezes and s_tready
//   drops, so no beat is lost or repeated. Bubbles stay in the pipeline.
// Reset:
//   rst_n clears all valid bits and loads the registers with 1200 mV,
//   1430 mV and 4.3 mV/K.
`default_nettype none

module adc_ratiometric_scaler_top #(
    parameter int ADC_BITS = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: vref_raw[11:0], temp_raw[23:12], led_raw[35:24], bat_raw[47:36]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // m_tdata: bat_mv[15:0], led_mv[31:16], temp_c[40:32], volt_saturated[41],
    //          ref_zero[42], zero fill[47:43]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata
);

    localparam int AW    = arsc_pkg::ADC_W;
    localparam int RW    = arsc_pkg::REF_W;
    localparam int KB_W  = RW + arsc_pkg::BAT_NUM_W;
    localparam int KL_W  = RW + arsc_pkg::LED_NUM_W;
    localparam int NB_W  = KB_W + AW;
    localparam int NL_W  = KL_W + AW;
    localparam int NS_W  = RW + AW;
    localparam int DB_W  = AW + arsc_pkg::DEN_W;
    localparam int VQ    = arsc_pkg::VOLT_Q_W;
    localparam int SQ    = arsc_pkg::SENSE_Q_W;
    localparam int TQ    = arsc_pkg::TEMP_Q_W;
    localparam int DIFF_W = SQ + 1;
    localparam int MAG_W  = SQ + 4;

    localparam int V_OUT  = 2 + VQ + 1;
    localparam int S_OUT  = 2 + SQ + 1;
    localparam int T_IN   = S_OUT + 1;
    localparam int T_OUT  = T_IN + TQ + 1;
    localparam int LAST   = T_OUT;
    localparam int V_DLY  = LAST - V_OUT;
    localparam int N_DLY  = T_OUT - T_IN;
    localparam int Z_DLY  = LAST - 2;

    localparam logic [AW-1:0] ADC_MASK =
        (ADC_BITS >= AW) ? {AW{1'b1}} : AW'((32'd1 << ADC_BITS) - 32'd1);

    arsc_pkg::in_beat_t  in_beat;
    arsc_pkg::out_beat_t out_reg;
    arsc_pkg::out_beat_t out_next;
    arsc_pkg::volt_res_t volt_res;
    arsc_pkg::volt_res_t volt_dly;

    logic en;

    logic [RW-1:0]                    ref_mv_reg;
    logic [RW-1:0]                    sense_25_reg;
    logic [arsc_pkg::SLOPE_W-1:0]     slope_reg;
    logic [arsc_pkg::SLOPE_W-1:0]     slope_eff;

    logic [LAST:1] valid_reg;
    logic          out_valid_reg;

    logic [AW-1:0] vref_m, traw_m, lraw_m, braw_m;

    logic [AW-1:0]   p1_vref_reg;
    logic [AW-1:0]   p1_lraw_reg;
    logic [AW-1:0]   p1_braw_reg;
    logic [KB_W-1:0] p1_kb_reg;
    logic [KL_W-1:0] p1_kl_reg;
    logic [NS_W-1:0] p1_ns_reg;
    logic [DB_W-1:0] p1_db_reg;
    logic            p1_zero_reg;

    logic [NB_W-1:0] p2_nb_reg;
    logic [NL_W-1:0] p2_nl_reg;
    logic [NS_W-1:0] p2_ns_reg;
    logic [DB_W-1:0] p2_db_reg;
    logic [AW-1:0]   p2_dv_reg;
    logic            p2_zero_reg;

    logic [SQ-1:0]            sense_q;
    logic                     sense_ovf;
    logic [SQ-1:0]            sense_sat;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [MAG_W-1:0]         mag10_next;
    logic [MAG_W-1:0]         t_mag_reg;
    logic                     t_neg_reg;
    logic                     t_neg_dly;

    logic [TQ-1:0] temp_q;
    logic          temp_ovf;
    logic          zero_dly;
    logic          bat_sat, led_sat;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign in_beat  = arsc_pkg::in_beat_t'(s_tdata);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 48'(out_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_mv_reg   <= arsc_pkg::REF_MV_RST;
            sense_25_reg <= arsc_pkg::SENSE_25_RST;
            slope_reg    <= arsc_pkg::SLOPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arsc_pkg::CFG_REF_MV:   ref_mv_reg   <= cfg_wdata;
                arsc_pkg::CFG_SENSE_25: sense_25_reg <= cfg_wdata;
                arsc_pkg::CFG_SLOPE:    slope_reg    <= cfg_wdata[arsc_pkg::SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    assign slope_eff = (slope_reg == '0) ? arsc_pkg::SLOPE_W'(1) : slope_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[LAST-1:1], s_tvalid};
            out_valid_reg <= valid_reg[LAST];
        end
    end

    assign vref_m = in_beat.vref_raw & ADC_MASK;
    assign traw_m = in_beat.temp_raw & ADC_MASK;
    assign lraw_m = in_beat.led_raw & ADC_MASK;
    assign braw_m = in_beat.bat_raw & ADC_MASK;

    // stage 1: coefficient products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_vref_reg <= vref_m;
            p1_lraw_reg <= lraw_m;
            p1_braw_reg <= braw_m;
            p1_kb_reg   <= KB_W'(ref_mv_reg) * KB_W'(arsc_pkg::BAT_NUM);
            p1_kl_reg   <= KL_W'(ref_mv_reg) * KL_W'(arsc_pkg::LED_NUM);
            p1_ns_reg   <= NS_W'(ref_mv_reg) * NS_W'(traw_m);
            p1_db_reg   <= DB_W'(vref_m) * DB_W'(arsc_pkg::DIV_DEN);
            p1_zero_reg <= (vref_m == '0);
        end
    end

    // stage 2: full numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_nb_reg   <= NB_W'(p1_kb_reg) * NB_W'(p1_braw_reg);
            p2_nl_reg   <= NL_W'(p1_kl_reg) * NL_W'(p1_lraw_reg);
            p2_ns_reg   <= p1_ns_reg;
            p2_db_reg   <= p1_db_reg;
            p2_dv_reg   <= p1_vref_reg;
            p2_zero_reg <= p1_zero_reg;
        end
    end

    arsc_div #(.NW(NB_W), .DW(DB_W), .QW(VQ)) u_div_bat (
        .clk (clk),
        .en  (en),
        .num (p2_nb_reg),
        .den (p2_db_reg),
        .quo (volt_res.bat_q),
        .ovf (volt_res.bat_ovf)
    );

    arsc_div #(.NW(NL_W), .DW(DB_W), .QW(VQ)) u_div_led (
        .clk (clk),
        .en  (en),
        .num (p2_nl_reg),
        .den (p2_db_reg),
        .quo (volt_res.led_q),
        .ovf (volt_res.led_ovf)
    );

    arsc_div #(.NW(NS_W), .DW(AW), .QW(SQ)) u_div_sense (
        .clk (clk),
        .en  (en),
        .num (p2_ns_reg),
        .den (p2_dv_reg),
        .quo (sense_q),
        .ovf (sense_ovf)
    );

    // sense clipped at 2^SQ-1: anything above already pins the low clamp
    always_comb
    begin
        sense_sat  = sense_ovf ? {SQ{1'b1}} : sense_q;
        diff       = $signed(DIFF_W'(sense_25_reg)) - $signed(DIFF_W'(sense_sat));
        mag        = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag10_next = (MAG_W'(mag) << 3) + (MAG_W'(mag) << 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_mag_reg <= mag10_next;
            t_neg_reg <= diff[DIFF_W-1];
        end
    end

    arsc_div #(.NW(MAG_W), .DW(arsc_pkg::SLOPE_W), .QW(TQ)) u_div_temp (
        .clk (clk),
        .en  (en),
        .num (t_mag_reg),
        .den (slope_eff),
        .quo (temp_q),
        .ovf (temp_ovf)
    );

    arsc_delay #(.W($bits(arsc_pkg::volt_res_t)), .DEPTH(V_DLY)) u_dly_volt (
        .clk  (clk),
        .en   (en),
        .din  (volt_res),
        .dout (volt_dly)
    );

    arsc_delay #(.W(1), .DEPTH(N_DLY)) u_dly_neg (
        .clk  (clk),
        .en   (en),
        .din  (t_neg_reg),
        .dout (t_neg_dly)
    );

    arsc_delay #(.W(1), .DEPTH(Z_DLY)) u_dly_zero (
        .clk  (clk),
        .en   (en),
        .din  (p2_zero_reg),
        .dout (zero_dly)
    );

    // final stage: zero-reference clear, saturate, sign, offset, clamp
    always_comb
    begin
        bat_sat  = volt_dly.bat_ovf || volt_dly.bat_q[VQ-1];
        led_sat  = volt_dly.led_ovf || volt_dly.led_q[VQ-1];
        out_next = '0;
        if (zero_dly)
        begin
            out_next.ref_zero = 1'b1;
        end
        else
        begin
            out_next.bat_mv = bat_sat ? arsc_pkg::VOLT_MAX
                                      : volt_dly.bat_q[arsc_pkg::VOLT_W-1:0];
            out_next.led_mv = led_sat ? arsc_pkg::VOLT_MAX
                                      : volt_dly.led_q[arsc_pkg::VOLT_W-1:0];
            out_next.volt_saturated = bat_sat || led_sat;
            if (t_neg_dly)
            begin
                if (temp_ovf || temp_q >= arsc_pkg::TEMP_NEG_LIM)
                    out_next.temp_c = arsc_pkg::TEMP_MIN;
                else
                    out_next.temp_c = $signed(arsc_pkg::TEMP_OFS - temp_q);
            end
            else
            begin
                if (temp_ovf || temp_q >= arsc_pkg::TEMP_POS_LIM)
                    out_next.temp_c = arsc_pkg::TEMP_MAX;
                else
                    out_next.temp_c = $signed(arsc_pkg::TEMP_OFS + temp_q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> out_valid_reg == $past(valid_reg[LAST]))
        else $error("output valid does not follow pipeline valid");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.ref_zero |-> out_reg.bat_mv == '0 && out_reg.led_mv == '0
            && out_reg.temp_c == '0 && !out_reg.volt_saturated)
        else $error("zero reference result carries data");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.temp_c >= arsc_pkg::TEMP_MIN
            && out_reg.temp_c <= arsc_pkg::TEMP_MAX)
        else $error("temperature outside clamp range");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.volt_saturated |->
            out_reg.bat_mv == arsc_pkg::VOLT_MAX || out_reg.led_mv == arsc_pkg::VOLT_MAX)
        else $error("saturation flag without saturated voltage");

endmodule

`default_nettype wire

@@ sim/adc_ratiometric_scaler_top_tb.sv @@
// Testbench: ratiometric ADC scaler, stream stimulus checked against a scoreboard predictor.
`timescale 1ns / 100ps

module adc_ratiometric_scaler_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int STALL_PCT      = 7;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int PRESSURE_ITEM  = 120;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [arsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class scaler_scoreboard;
        logic [arsc_pkg::REF_W-1:0]   ref_mv;
        logic [arsc_pkg::REF_W-1:0]   sense_25;
        logic [arsc_pkg::SLOPE_W-1:0] slope;
        arsc_pkg::out_beat_t          expected_readings[$];
        int                           errors;

        function new();
            ref_mv   = arsc_pkg::REF_MV_RST;
            sense_25 = arsc_pkg::SENSE_25_RST;
            slope    = arsc_pkg::SLOPE_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [arsc_pkg::CFG_IDX_W-1:0] idx,
                              logic [arsc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                arsc_pkg::CFG_REF_MV:   ref_mv = val;
                arsc_pkg::CFG_SENSE_25: sense_25 = val;
                arsc_pkg::CFG_SLOPE:    slope = val[arsc_pkg::SLOPE_W-1:0];
                default:      ;
            endcase
        endfunction

        function arsc_pkg::out_beat_t scale_sample(arsc_pkg::in_beat_t smp);
            arsc_pkg::out_beat_t r;
            longint unsigned     vr, refv, bat, led, sense_u;
            longint              sense, t, sl, s25;
            r = '0;
            if (smp.vref_raw == '0)
            begin
                r.ref_zero = 1'b1;
                return r;
            end
            vr   = smp.vref_raw;
            refv = ref_mv;
            bat  = (refv * arsc_pkg::BAT_NUM * smp.bat_raw) / (vr * arsc_pkg::DIV_DEN);
            led  = (refv * arsc_pkg::LED_NUM * smp.led_raw) / (vr * arsc_pkg::DIV_DEN);
            if (bat > arsc_pkg::VOLT_MAX)
            begin
                bat = arsc_pkg::VOLT_MAX;
                r.volt_saturated = 1'b1;
            end
            if (led > arsc_pkg::VOLT_MAX)
            begin
                led = arsc_pkg::VOLT_MAX;
                r.volt_saturated = 1'b1;
            end
            sense_u = (refv * smp.temp_raw) / vr;
            sense   = sense_u;
            s25     = sense_25;
            sl      = (slope == '0) ? 1 : slope;
            // signed division truncates toward zero
            t = ((s25 - sense) * 10) / sl + 25;
            if (t < -65)
                t = -65;
            else if (t > 150)
                t = 150;
            r.bat_mv = bat[arsc_pkg::VOLT_W-1:0];
            r.led_mv = led[arsc_pkg::VOLT_W-1:0];
            r.temp_c = t[arsc_pkg::TEMP_W-1:0];
            return r;
        endfunction

        function void note_sample(arsc_pkg::in_beat_t smp);
            expected_readings.push_back(scale_sample(smp));
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_reading(arsc_pkg::out_beat_t got);
            arsc_pkg::out_beat_t exp_r;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_readings.pop_front();
            compare_field("bat_mv", exp_r.bat_mv, got.bat_mv);
            compare_field("led_mv", exp_r.led_mv, got.led_mv);
            compare_field("temp_c", exp_r.temp_c, got.temp_c);
            compare_field("volt_saturated", exp_r.volt_saturated, got.volt_saturated);
            compare_field("ref_zero", exp_r.ref_zero, got.ref_zero);
            compare_field("zero fill", exp_r.pad, got.pad);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    arsc_pkg::in_beat_t              s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [47:0]                     m_tdata;
    logic                            cfg_we = 1'b0;
    logic [arsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [arsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            steady = 1'b0;
    int                              quiet_cycles = 0;
    scaler_scoreboard                sb;

    adc_ratiometric_scaler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(arsc_pkg::out_beat_t'(m_tdata));
        m_tready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input arsc_pkg::in_beat_t smp);
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= smp;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(smp);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [arsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arsc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_scaling(input logic [arsc_pkg::CFG_DATA_W-1:0] ref_val,
                               input logic [arsc_pkg::CFG_DATA_W-1:0] s25_val,
                               input logic [arsc_pkg::CFG_DATA_W-1:0] slope_val);
        write_reg(arsc_pkg::CFG_REF_MV, ref_val);
        write_reg(arsc_pkg::CFG_SENSE_25, s25_val);
        write_reg(arsc_pkg::CFG_SLOPE, slope_val);
    endtask

    function automatic arsc_pkg::in_beat_t make_sample(logic [arsc_pkg::ADC_W-1:0] vref,
                                                       logic [arsc_pkg::ADC_W-1:0] temp,
                                                       logic [arsc_pkg::ADC_W-1:0] led,
                                                       logic [arsc_pkg::ADC_W-1:0] bat);
        arsc_pkg::in_beat_t s;
        s.vref_raw = vref;
        s.temp_raw = temp;
        s.led_raw  = led;
        s.bat_raw  = bat;
        return s;
    endfunction

    function automatic logic [arsc_pkg::ADC_W-1:0] edge_or_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        else if (pick < 10)
            return '1;
        return arsc_pkg::ADC_W'($urandom_range(4095));
    endfunction

    function automatic arsc_pkg::in_beat_t random_sample();
        arsc_pkg::in_beat_t s;
        int                 pick, deg;
        longint             sl, sense_mv, raw;
        s.temp_raw = edge_or_random();
        s.led_raw  = edge_or_random();
        s.bat_raw  = edge_or_random();
        pick = $urandom_range(99);
        if (pick < 4)
            s.vref_raw = '0;
        else if (pick < 20)
            s.vref_raw = arsc_pkg::ADC_W'($urandom_range(63, 1));
        else if (pick < 35)
            s.vref_raw = edge_or_random();
        else
            s.vref_raw = arsc_pkg::ADC_W'($urandom_range(1700, 1200));
        // aim the sensor reading at -80 C to 160 C, around and across both temperature clamps
        if (s.vref_raw != '0 && sb.ref_mv != '0 && $urandom_range(99) < 40)
        begin
            deg      = int'($urandom_range(240)) - 80;
            sl       = (sb.slope == '0) ? 1 : sb.slope;
            sense_mv = longint'(sb.sense_25) - (deg - 25) * sl / 10;
            raw      = sense_mv * longint'(s.vref_raw) / longint'(sb.ref_mv)
                       + int'($urandom_range(2)) - 1;
            if (raw < 0)
                raw = 0;
            else if (raw > 4095)
                raw = 4095;
            s.temp_raw = raw[arsc_pkg::ADC_W-1:0];
        end
        return s;
    endfunction

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets under reset scaling
        send_sample(make_sample(12'd0, 12'd0, 12'd0, 12'd0));
        send_sample(make_sample(12'd0, 12'd4095, 12'd4095, 12'd4095));
        send_sample(make_sample(12'd4095, 12'd4095, 12'd4095, 12'd4095));
        send_sample(make_sample(12'd1, 12'd4095, 12'd4095, 12'd4095));
        send_sample(make_sample(12'd1, 12'd0, 12'd0, 12'd0));
        send_sample(make_sample(12'd4095, 12'd0, 12'd0, 12'd0));
        send_sample(make_sample(12'd1489, 12'd1774, 12'd2000, 12'd1000));
        send_sample(make_sample(12'd1489, 12'd2000, 12'd1500, 12'd500));
        send_sample(make_sample(12'd1489, 12'd1500, 12'd2500, 12'd3000));
        send_sample(make_sample(12'd1489, 12'd1781, 12'd1, 12'd1));
        send_sample(make_sample(12'd100, 12'd1000, 12'd100, 12'd4095));
        send_sample(make_sample(12'd50, 12'd1000, 12'd4095, 12'd0));
        send_sample(make_sample(12'hAAA, 12'h555, 12'h555, 12'h555));
        send_sample(make_sample(12'h555, 12'hAAA, 12'hAAA, 12'hAAA));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            steady <= (phase == 2);
            case (phase)
                0: set_scaling(12'd3300, 12'd3300, 12'd255);
                1: set_scaling(12'd1, 12'd0, 12'd1);
                2: set_scaling(12'd0, 12'd4095, 12'd0);
                3:
                begin
                    set_scaling(12'd4095, 12'd0, 12'hF7B);
                    write_reg(CFG_UNUSED, 12'hFFF);
                end
                4: set_scaling(12'd1210, 12'd1430, 12'd43);
                default:
                begin
                    write_reg(CFG_UNUSED, arsc_pkg::CFG_DATA_W'($urandom_range(4095)));
                    set_scaling(arsc_pkg::CFG_DATA_W'($urandom_range(3300, 1)),
                                arsc_pkg::CFG_DATA_W'($urandom_range(3300)),
                                arsc_pkg::CFG_DATA_W'($urandom_range(4095)));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 1 && i == PRESSURE_ITEM)
                    wait_drained();
                send_sample(random_sample());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/arsc_pkg.sv
hw/rtl/arsc_div.sv
hw/rtl/arsc_delay.sv
hw/rtl/adc_ratiometric_scaler_top.sv
sim/adc_ratiometric_scaler_top_tb.sv
